FILE: sv/vn_pkg.sv
package vn_pkg;

  localparam int unsigned COMP_WIDTH_DEF = 16;
  localparam int unsigned FRAC_EXTRA     = 8;
  localparam int unsigned Q_BITS         = 15;
  localparam int unsigned OUT_W          = 16;
  localparam logic [Q_BITS-1:0] Q14_ONE  = 15'd16384;

endpackage

FILE: sv/vn_sqrt_cell.sv
module vn_sqrt_cell #(
  parameter int unsigned RW     = 24,
  parameter int unsigned SIDE_W = 52
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*RW-1:0]     rad_i,
  input  logic [RW+1:0]       rem_i,
  input  logic [RW-1:0]       root_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [2*RW-1:0]     rad_o,
  output logic [RW+1:0]       rem_o,
  output logic [RW-1:0]       root_o,
  output logic [SIDE_W-1:0]   side_o
);
  logic [RW+1:0] rem_sh, trial;
  logic          ge;

  // one root digit per cell, restoring form
  assign rem_sh = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
  assign trial  = {root_i, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      rem_o  <= ge ? rem_sh - trial : rem_sh;
      root_o <= {root_i[RW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

FILE: sv/vn_div_cell.sv
module vn_div_cell #(
  parameter int unsigned DW     = 24,
  parameter int unsigned QW     = 15,
  parameter int unsigned SIDE_W = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [DW-1:0]       d_i,
  input  logic [3*DW-1:0]     rem_i,
  input  logic [3*QW-1:0]     q_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [DW-1:0]       d_o,
  output logic [3*DW-1:0]     rem_o,
  output logic [3*QW-1:0]     q_o,
  output logic [SIDE_W-1:0]   side_o
);
  logic [3*DW-1:0] rem_d;
  logic [3*QW-1:0] q_d;

  // one quotient bit per lane per cell, divisor shared by the three lanes
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [DW:0] rem_sh, diff;
    logic        ge;
    assign rem_sh = {rem_i[l*DW +: DW], 1'b0};
    assign diff   = rem_sh - {1'b0, d_i};
    assign ge     = rem_sh >= {1'b0, d_i};
    assign rem_d[l*DW +: DW] = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    assign q_d[l*QW +: QW]   = {q_i[l*QW +: QW-1], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o    <= d_i;
      rem_o  <= rem_d;
      q_o    <= q_d;
      side_o <= side_i;
    end
  end

endmodule

FILE: sv/vector3_normalize.sv
// Normalises one signed 3-vector per transfer: gives floor(sqrt(x^2+y^2+z^2)) and the unit vector
// in Q1.14 (truncated, clamped to +-16384; a zero vector gives zeros and is_zero). Fully pipelined,
// one vector per clock. After the input, square and sum registers comes a row of COMP_WIDTH+8
// square-root cells, one root bit each, then 15 divider cells, one quotient bit each for all
// three components, then the output register. The whole pipe stalls only while a result waits
// and m_axis_tready_i is low.
module vector3_normalize
  import vn_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = vn_pkg::COMP_WIDTH_DEF,
  parameter int unsigned IN_W       = ((3 * COMP_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // comp_x, comp_y, comp_z, zero padding
  input  logic [IN_W-1:0]       s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // unit_x, unit_y, unit_z, vec_length
  output logic [4*vn_pkg::OUT_W-1:0] m_axis_tdata_o,
  // is_zero
  output logic                  m_axis_tuser_o
);
  localparam int unsigned W      = COMP_WIDTH;
  localparam int unsigned RW     = W + FRAC_EXTRA;
  localparam int unsigned NS     = RW;
  localparam int unsigned NQ     = Q_BITS;
  localparam int unsigned SQ_S   = 3 * W + 4;
  localparam int unsigned DV_S   = 4;

  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // input stage: magnitudes and signs
  logic [2:0]     v_q;
  logic [W-1:0]   mag_q  [3];
  logic [2:0]     neg_q;
  logic [2*W-1:0] sq_q   [3];
  logic [2:0]     neg2_q;
  logic [W-1:0]   mag2_q [3];
  logic [2*W-1:0] sum_q;
  logic [2:0]     neg3_q;
  logic [W-1:0]   mag3_q [3];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic [W-1:0] raw;
    assign raw = s_axis_tdata_i[c*W +: W];
    always_ff @(posedge clk_i) begin
      if (en) begin
        neg_q[c]  <= raw[W-1];
        mag_q[c]  <= raw[W-1] ? W'(~raw + 1'b1) : raw;
        sq_q[c]   <= mag_q[c] * mag_q[c];
        neg2_q[c] <= neg_q[c];
        mag2_q[c] <= mag_q[c];
        neg3_q[c] <= neg2_q[c];
        mag3_q[c] <= mag2_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[1:0], s_axis_tvalid_i};
    end
  end

  // square-root row
  logic             sv    [NS+1];
  logic [2*RW-1:0]  srad  [NS+1];
  logic [RW+1:0]    srem  [NS+1];
  logic [RW-1:0]    sroot [NS+1];
  logic [SQ_S-1:0]  sside [NS+1];

  assign sv[0]    = v_q[2];
  assign srad[0]  = {sum_q, {(2*FRAC_EXTRA){1'b0}}};
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = {sum_q == '0, neg3_q, mag3_q[2], mag3_q[1], mag3_q[0]};

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    vn_sqrt_cell #(.RW(RW), .SIDE_W(SQ_S)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[i]),
      .rad_i   (srad[i]),
      .rem_i   (srem[i]),
      .root_i  (sroot[i]),
      .side_i  (sside[i]),
      .valid_o (sv[i+1]),
      .rad_o   (srad[i+1]),
      .rem_o   (srem[i+1]),
      .root_o  (sroot[i+1]),
      .side_o  (sside[i+1])
    );
  end

  // divider row
  logic             dv    [NQ+1];
  logic [RW-1:0]    dd    [NQ+1];
  logic [3*RW-1:0]  drem  [NQ+1];
  logic [3*NQ-1:0]  dq    [NQ+1];
  logic [DV_S-1:0]  dside [NQ+1];

  assign dv[0]    = sv[NS];
  assign dd[0]    = sroot[NS];
  assign dq[0]    = '0;
  assign dside[0] = sside[NS][SQ_S-1 -: DV_S];
  for (genvar c = 0; c < 3; c++) begin : g_dinit
    assign drem[0][c*RW +: RW] = {1'b0, sside[NS][c*W +: W], 7'd0};
  end

  for (genvar i = 0; i < NQ; i++) begin : g_div
    vn_div_cell #(.DW(RW), .QW(NQ), .SIDE_W(DV_S)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[i]),
      .d_i     (dd[i]),
      .rem_i   (drem[i]),
      .q_i     (dq[i]),
      .side_i  (dside[i]),
      .valid_o (dv[i+1]),
      .d_o     (dd[i+1]),
      .rem_o   (drem[i+1]),
      .q_o     (dq[i+1]),
      .side_o  (dside[i+1])
    );
  end

  // output register
  logic              zero;
  logic [OUT_W-1:0]  len16;
  logic [W-1:0]      len_w;
  logic [4*OUT_W-1:0] data_d;

  assign zero  = dside[NQ][DV_S-1];
  assign len_w = dd[NQ][RW-1:FRAC_EXTRA];

  if (W > OUT_W) begin : g_len_sat
    assign len16 = (|len_w[W-1:OUT_W]) ? '1 : len_w[OUT_W-1:0];
  end else begin : g_len_ext
    assign len16 = OUT_W'(len_w);
  end

  for (genvar c = 0; c < 3; c++) begin : g_unit
    logic [NQ-1:0]    q, qc;
    logic [OUT_W-1:0] u;
    assign q  = dq[NQ][c*NQ +: NQ];
    assign qc = (q > Q14_ONE) ? Q14_ONE : q;
    assign u  = dside[NQ][c] ? OUT_W'(-{1'b0, qc}) : OUT_W'({1'b0, qc});
    assign data_d[c*OUT_W +: OUT_W] = zero ? '0 : u;
  end
  assign data_d[3*OUT_W +: OUT_W] = zero ? '0 : len16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (en) begin
      m_axis_tvalid_o <= dv[NQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata_o <= data_d;
      m_axis_tuser_o <= zero;
    end
  end

endmodule

FILE: dv/vector3_normalize_tb.sv
module vector3_normalize_tb;
  import vn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW   = COMP_WIDTH_DEF;
  localparam int unsigned IN_W = ((3 * CW + 7) / 8) * 8;
  localparam int unsigned LAT  = CW + 27;
  localparam int NUM_RAND = 1400;

  typedef struct packed {
    logic signed [OUT_W-1:0] ux;
    logic signed [OUT_W-1:0] uy;
    logic signed [OUT_W-1:0] uz;
    logic [OUT_W-1:0]        len;
    logic                    zero;
  } norm_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    bit                   typed;
    norm_t                res;
  } vec_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [4*OUT_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  norm_t expected_q[$];
  int errors = 0;
  int mismatches = 0;
  int n_results = 0;
  int n_zero = 0;
  int n_clamp = 0;
  int snd_idle = 0;
  int rcv_stall = 0;
  bit hold_off = 1'b0;

  always #2 clk_i = ~clk_i;

  vector3_normalize u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // floor(sqrt(s) * 256) by the bitwise method
  function automatic logic [63:0] root_q8(logic [63:0] s);
    logic [79:0] v;
    logic [79:0] rem;
    logic [79:0] root;
    logic [79:0] trial;
    v = {s, 16'h0};
    rem = '0;
    root = '0;
    for (int i = 39; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 80'd3);
      trial = (root << 2) | 80'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 80'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic logic [OUT_W-1:0] unit_part(logic signed [CW-1:0] c, logic [63:0] lq);
    logic [63:0] mag;
    logic [63:0] q;
    if (c[CW-1]) mag = (64'd1 << CW) - 64'(unsigned'(c));
    else mag = 64'(unsigned'(c));
    q = (mag << 22) / lq;
    if (q > 64'd16384) q = 64'd16384;
    if (c[CW-1]) q = -q;
    return q[OUT_W-1:0];
  endfunction

  function automatic norm_t normalise(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                      logic signed [CW-1:0] z);
    norm_t r;
    logic [63:0] s;
    logic [63:0] lq;
    logic [63:0] l;
    s = 64'($signed(64'(x)) * $signed(64'(x))) + 64'($signed(64'(y)) * $signed(64'(y)))
      + 64'($signed(64'(z)) * $signed(64'(z)));
    if (s == 0) begin
      r = '0;
      r.zero = 1'b1;
      return r;
    end
    lq = root_q8(s);
    l = lq >> FRAC_EXTRA;
    r.len = (l > 64'hFFFF) ? 16'hFFFF : l[OUT_W-1:0];
    r.ux = unit_part(x, lq);
    r.uy = unit_part(y, lq);
    r.uz = unit_part(z, lq);
    r.zero = 1'b0;
    return r;
  endfunction

  // one transfer from the sender side, idling at random
  task automatic send_vec(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                          logic signed [CW-1:0] z);
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= IN_W'({z, y, x});
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic push_vec(vec_row_t r);
    norm_t p;
    p = normalise(r.x, r.y, r.z);
    if (r.typed && p !== r.res) begin
      errors++;
      $display("predictor disagrees with table for %0d %0d %0d", r.x, r.y, r.z);
    end
    expected_q.push_back(r.typed ? r.res : p);
    send_vec(r.x, r.y, r.z);
  endtask

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return logic'($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
      1: return CW'($signed($urandom_range(8)) - 4);
      2: return CW'($urandom_range(255));
      default: return CW'($urandom);
    endcase
  endfunction

  // receiver stall control
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= rcv_stall);
  end

  // result checker
  always @(posedge clk_i) begin
    norm_t got;
    norm_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[15:0], m_axis_tdata_o[31:16], m_axis_tdata_o[47:32],
             m_axis_tdata_o[63:48], m_axis_tuser_o};
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.zero) n_zero++;
        if (got.ux == 16384 || got.ux == -16384) n_clamp++;
        if (got !== exp_r) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp ux %0d uy %0d uz %0d len %0d zero %0b, ",
                      "got %0d %0d %0d %0d %0b"},
                     exp_r.ux, exp_r.uy, exp_r.uz, exp_r.len, exp_r.zero,
                     got.ux, got.uy, got.uz, got.len, got.zero);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    vec_row_t tbl[$];
    vec_row_t r;
    int wait_cnt;
    // directed rows: zero vector, axes, extremes, small odd lengths
    tbl.push_back('{0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b1}});
    tbl.push_back('{1, 0, 0, 1'b1, '{16384, 0, 0, 1, 1'b0}});
    tbl.push_back('{0, -1, 0, 1'b1, '{0, -16384, 0, 1, 1'b0}});
    tbl.push_back('{0, 0, 32767, 1'b1, '{0, 0, 16384, 32767, 1'b0}});
    tbl.push_back('{-32768, 0, 0, 1'b1, '{-16384, 0, 0, 32768, 1'b0}});
    tbl.push_back('{-32768, -32768, -32768, 1'b0, '{0, 0, 0, 0, 1'b0}});
    tbl.push_back('{32767, 32767, 32767, 1'b0, '{0, 0, 0, 0, 1'b0}});
    tbl.push_back('{32767, -32768, 32767, 1'b0, '{0, 0, 0, 0, 1'b0}});
    tbl.push_back('{1, 1, 1, 1'b0, '{0, 0, 0, 0, 1'b0}});
    tbl.push_back('{-1, 1, -1, 1'b0, '{0, 0, 0, 0, 1'b0}});
    tbl.push_back('{3, 4, 0, 1'b0, '{0, 0, 0, 0, 1'b0}});
    tbl.push_back('{2, 3, 6, 1'b0, '{0, 0, 0, 0, 1'b0}});
    tbl.push_back('{-21845, 10922, 5461, 1'b0, '{0, 0, 0, 0, 1'b0}});
    tbl.push_back('{1, 0, -32768, 1'b0, '{0, 0, 0, 0, 1'b0}});
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (tbl[i]) push_vec(tbl[i]);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 78; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 78; end
        3: begin snd_idle = 28; rcv_stall = 28; end
        default: begin snd_idle = 0; rcv_stall = 0; end
      endcase
      for (int k = 0; k < NUM_RAND / 5; k++) begin
        if (ph == 4 && k == 10) hold_off = 1'b1;
        r.x = rand_comp();
        r.y = rand_comp();
        r.z = rand_comp();
        if ($urandom_range(40) == 0) begin r.x = 0; r.y = 0; r.z = 0; end
        r.typed = 1'b0;
        r.res = '0;
        push_vec(r);
      end
    end
    s_axis_tvalid_i <= 1'b0;
    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (LAT + 10) @(posedge clk_i);
    if (expected_q.size() != 0) errors++;
    $display("covered %0d vectors, %0d zero, %0d clamped x,", n_results, n_zero, n_clamp);
    $display("idle and stall phases plus a long hold-off");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // long receiver hold-off, counted in cycles, so the pipe fills and stalls the sender
  initial begin
    wait (hold_off);
    repeat (LAT * 3) @(posedge clk_i);
    hold_off = 1'b0;
  end

endmodule

FILE: files.f
sv/vn_pkg.sv
sv/vn_sqrt_cell.sv
sv/vn_div_cell.sv
sv/vector3_normalize.sv
dv/vector3_normalize_tb.sv
